FILE: hdl/bdag_pkg.sv
// Package for the beamforming delay address generator.
// Holds payload structs and fixed-point constants; no dependencies.
package bdag_pkg;

    typedef struct packed {
        logic [6:0]  pixel_row;
        logic [6:0]  pixel_col;
        logic [11:0] newest_addr;
    } in_word_t;

    typedef struct packed {
        logic [47:0] left_addrs_low;
        logic [47:0] left_addrs_high;
        logic [47:0] right_addrs_low;
        logic [47:0] right_addrs_high;
        logic [39:0] left_weights;
        logic [47:0] right_weights;
    } out_word_t;

    localparam logic [1:0] REG_X     = 2'd0;
    localparam logic [1:0] REG_Y     = 2'd1;
    localparam logic [1:0] REG_FOCAL = 2'd2;

    localparam logic [14:0] FOCAL_RESET = 15'd15877;
    localparam int SQRT_STEPS = 18;   // result bits of sqrt(d2 << 18), 35-bit radicand
    localparam int QUOT_BITS  = 10;   // delay wraps to 10 bits, only low bits needed

endpackage

FILE: hdl/bdag_sqrt_stage.sv
// One restoring square-root step (one result bit).
// Depends on nothing; chained by beamform_delay_address_gen.
module bdag_sqrt_stage (
    input  logic [35:0] rem_in,
    input  logic [17:0] root_in,
    input  logic [1:0]  pair,
    output logic [35:0] rem_out,
    output logic [17:0] root_out
);
    logic [37:0] shifted;
    logic [37:0] trial;

    // Bring down two bits and try root*4+1
    always_comb
    begin
        shifted = {rem_in, pair};
        trial   = {18'd0, root_in, 2'b01};
        if (shifted >= trial)
        begin
            rem_out  = 36'(shifted - trial);
            root_out = {root_in[16:0], 1'b1};
        end
        else
        begin
            rem_out  = shifted[35:0];
            root_out = {root_in[16:0], 1'b0};
        end
    end
endmodule

FILE: hdl/bdag_divider.sv
// Pipelined signed floor divider: q = floor(num / den), low QUOT_BITS of q.
// Uses bdag_pkg; NUM_BITS + 2 registered stages in all, one quotient bit per low stage.
module bdag_divider #(
    parameter int NUM_BITS = 30
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [NUM_BITS-1:0] num,
    input  logic [17:0]         den,
    output logic [9:0]          quot
);
    localparam int QB = bdag_pkg::QUOT_BITS;

    // floor(n/d) for n<0 is -ceil(|n|/d) = ~floor((|n|-1)/d)
    // A zero divisor yields a zero quotient: divide zero by one instead.
    logic                neg_in;
    logic                zero_den;
    logic [NUM_BITS-1:0] mag_in;
    logic [17:0]         den_in;

    always_comb
    begin
        zero_den = (den == 18'd0);
        neg_in   = num[NUM_BITS-1] && !zero_den;
        if (zero_den)
            mag_in = '0;
        else
            mag_in = neg_in ? NUM_BITS'(~num) : num;
        den_in   = zero_den ? 18'd1 : den;
    end

    logic [NUM_BITS-1:0] mag_reg  [QB+1];
    logic [18:0]         rem_reg  [QB+1];
    logic [QB-1:0]       q_reg    [QB+1];
    logic                neg_reg  [QB+1];
    logic [17:0]         den_reg  [QB+1];

    // Stage 0: high part of the quotient is discarded by the 10-bit wrap,
    // so start from the remainder of mag >> QB modulo den.
    // Remainder of the high part is computed with a long division chain cut in stages.
    localparam int HB = NUM_BITS - QB;

    // High-part remainder: HB steps, split across the pre-pipeline below
    logic [18:0] hrem_reg [HB+1];
    logic [NUM_BITS-1:0] hmag_reg [HB+1];
    logic hneg_reg [HB+1];
    logic [17:0] hden_reg [HB+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= HB; k++)
            begin
                hneg_reg[k] <= 1'b0;
            end
        end
        else if (advance)
        begin
            hneg_reg[0] <= neg_in;
            for (int k = 1; k <= HB; k++)
            begin
                hneg_reg[k] <= hneg_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hrem_reg[0] <= '0;
            hmag_reg[0] <= mag_in;
            hden_reg[0] <= den_in;
            for (int k = 1; k <= HB; k++)
            begin
                logic [19:0] sh;
                sh = {hrem_reg[k-1], hmag_reg[k-1][NUM_BITS-k]};
                if (sh >= {2'b0, hden_reg[k-1]})
                    hrem_reg[k] <= 19'(sh - {2'b0, hden_reg[k-1]});
                else
                    hrem_reg[k] <= sh[18:0];
                hmag_reg[k] <= hmag_reg[k-1];
                hden_reg[k] <= hden_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QB; k++)
            begin
                neg_reg[k] <= 1'b0;
            end
        end
        else if (advance)
        begin
            neg_reg[0] <= hneg_reg[HB];
            for (int k = 1; k <= QB; k++)
            begin
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    // Low quotient bits, one per stage
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_reg[0] <= hrem_reg[HB];
            mag_reg[0] <= hmag_reg[HB];
            den_reg[0] <= hden_reg[HB];
            q_reg[0]   <= '0;
            for (int k = 1; k <= QB; k++)
            begin
                logic [19:0] sh;
                sh = {rem_reg[k-1], mag_reg[k-1][QB-k]};
                if (sh >= {2'b0, den_reg[k-1]})
                begin
                    rem_reg[k] <= 19'(sh - {2'b0, den_reg[k-1]});
                    q_reg[k]   <= {q_reg[k-1][QB-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k] <= sh[18:0];
                    q_reg[k]   <= {q_reg[k-1][QB-2:0], 1'b0};
                end
                mag_reg[k] <= mag_reg[k-1];
                den_reg[k] <= den_reg[k-1];
            end
        end
    end

    assign quot = neg_reg[QB] ? ~q_reg[QB] : q_reg[QB];
endmodule

FILE: hdl/beamform_delay_address_gen.sv
// Top level of the beamforming delay address generator.
// Uses bdag_pkg, bdag_sqrt_stage and bdag_divider.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one pixel word:
//   row, column and the newest circular-buffer address. Output channel
//   (out_valid/out_ready/out_data) returns one word per pixel: left and
//   right read addresses and interpolation weights for every sensor.
//   Configuration: cfg_we/cfg_index/cfg_data write sensor x, sensor y and
//   the focal distance squared; write only while the pipeline is empty.
//   Throughput: one word per cycle while out_ready does not stall. The pipeline
//   depth is 55 register stages: 2 offset/square stages, 19 square-root
//   stages (a load stage and 18 one-bit steps), 32 divider stages (two
//   load stages and 30 one-bit steps), then min-search and output stages.
//   The whole pipe advances together; a stall on out_ready freezes every
//   stage and drops in_ready only when the output register is full,
//   so nothing is lost or repeated.
//   Reset clears all valid bits and loads the default register values.
module beamform_delay_address_gen #(
    parameter int NUM_SENSORS      = 8,
    parameter int BUFFER_ADDR_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  bdag_pkg::in_word_t    in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output bdag_pkg::out_word_t   out_data,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [63:0]           cfg_data
);
    localparam int NS  = NUM_SENSORS;
    localparam int AB  = BUFFER_ADDR_BITS;
    localparam int NB  = 30;                  // t*2048 signed width
    localparam int SQ  = bdag_pkg::SQRT_STEPS;
    localparam int DIVL = NB + 2;             // divider depth in stages
    localparam int L_PRE = 2;
    localparam int L_DIV = L_PRE + SQ + 1 + DIVL; // delay values ready
    localparam int L_TOT = L_DIV + 2;         // min stage, address stage

    // Configuration registers
    logic [63:0] sx_reg, sy_reg;
    logic [14:0] focal_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg    <= '0;
            sy_reg    <= '0;
            focal_reg <= bdag_pkg::FOCAL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bdag_pkg::REG_X:     sx_reg    <= cfg_data;
                bdag_pkg::REG_Y:     sy_reg    <= cfg_data;
                bdag_pkg::REG_FOCAL: focal_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // Pipeline advances when the output register is free or being taken
    logic advance;
    logic [L_TOT:1] vld_reg;
    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;
    assign out_valid = vld_reg[L_TOT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (advance)
            vld_reg <= {vld_reg[L_TOT-1:1], in_valid};
    end

    // Stage 1: offsets in half units
    logic signed [7:0] drow1_reg, dcol1_reg;
    logic [11:0] now1_reg;
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            drow1_reg <= 8'({1'b0, in_data.pixel_row, 1'b0} - 9'd71);
            dcol1_reg <= 8'({1'b0, in_data.pixel_col, 1'b0} - 9'd127);
            now1_reg  <= in_data.newest_addr;
        end
    end

    // Stage 2: squares and d2 (quarter units, mod 2^17)
    logic [16:0] d2_reg;
    logic signed [7:0] drow2_reg, dcol2_reg;
    logic [11:0] now2_reg;
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            d2_reg <= 17'({4'd0, 13'(drow1_reg * drow1_reg)})
                    + 17'({3'd0, 14'(dcol1_reg * dcol1_reg)})
                    + {focal_reg, 2'b00};
            drow2_reg <= drow1_reg;
            dcol2_reg <= dcol1_reg;
            now2_reg  <= now1_reg;
        end
    end

    // Square root of d2 << 18, one result bit per stage
    logic [35:0] srem_reg [SQ+1];
    logic [17:0] sroot_reg [SQ+1];
    logic [35:0] srad_reg [SQ+1];
    logic signed [7:0] sdr_reg [SQ+1];
    logic signed [7:0] sdc_reg [SQ+1];
    logic [11:0] snow_reg [SQ+1];
    logic [35:0] srem_next [SQ];
    logic [17:0] sroot_next [SQ];

    for (genvar k = 0; k < SQ; k++)
    begin : g_sqrt
        bdag_sqrt_stage u_stage (
            .rem_in   (srem_reg[k]),
            .root_in  (sroot_reg[k]),
            .pair     (srad_reg[k][35-2*k -: 2]),
            .rem_out  (srem_next[k]),
            .root_out (sroot_next[k])
        );
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            srem_reg[0]  <= '0;
            sroot_reg[0] <= '0;
            srad_reg[0]  <= {1'b0, d2_reg, 18'd0};
            sdr_reg[0]   <= drow2_reg;
            sdc_reg[0]   <= dcol2_reg;
            snow_reg[0]  <= now2_reg;
            for (int k = 1; k <= SQ; k++)
            begin
                srem_reg[k]  <= srem_next[k-1];
                sroot_reg[k] <= sroot_next[k-1];
                srad_reg[k]  <= srad_reg[k-1];
                sdr_reg[k]   <= sdr_reg[k-1];
                sdc_reg[k]   <= sdc_reg[k-1];
                snow_reg[k]  <= snow_reg[k-1];
            end
        end
    end

    // Per-lane numerator t*2048 and division by d
    logic [9:0] delay_q [NS];
    logic [17:0] dq;
    assign dq = sroot_reg[SQ];

    for (genvar i = 0; i < NS; i++)
    begin : g_lane
        logic signed [7:0] cx, cy;
        if (i < 8)
        begin : g_coord
            assign cx = sx_reg[8*i +: 8];
            assign cy = sy_reg[8*i +: 8];
        end
        else
        begin : g_zero
            assign cx = '0;
            assign cy = '0;
        end
        // Combinational product sum feeds the divider directly
        logic signed [NB-1:0] num_c;
        assign num_c = NB'((cx * sdr_reg[SQ] + cy * sdc_reg[SQ]) * 2048);
        bdag_divider #(.NUM_BITS(NB)) u_div (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .num     (num_c),
            .den     (dq),
            .quot    (delay_q[i])
        );
    end

    // Carry newest address alongside the divider
    logic [11:0] dnow_reg [DIVL];
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dnow_reg[0] <= snow_reg[SQ];
            for (int k = 1; k < DIVL; k++)
                dnow_reg[k] <= dnow_reg[k-1];
        end
    end

    // Minimum stage
    logic signed [9:0] dl_reg [NS];
    logic signed [9:0] mn_reg;
    logic [11:0] mnow_reg;
    logic signed [9:0] mn_c;
    always_comb
    begin
        mn_c = $signed(delay_q[0]);
        for (int i = 1; i < NS; i++)
            if ($signed(delay_q[i]) < mn_c)
                mn_c = $signed(delay_q[i]);
    end
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < NS; i++)
                dl_reg[i] <= $signed(delay_q[i]);
            mn_reg   <= mn_c;
            mnow_reg <= dnow_reg[DIVL-1];
        end
    end

    // Address and weight packing
    bdag_pkg::out_word_t out_next;
    always_comb
    begin
        logic [191:0] la, ra;
        logic [39:0]  lw;
        logic [47:0]  rw;
        logic [9:0]   u;
        logic [AB-1:0] ar, al;
        la = '0; ra = '0; lw = '0; rw = '0;
        for (int i = 0; i < NS && i < 8; i++)
        begin
            u  = 10'(dl_reg[i] - mn_reg);
            ar = AB'({{(AB > 12 ? AB-12 : 0){1'b0}}, mnow_reg}) - AB'(u[9:5]);
            al = ar - AB'(1);
            la[i*24 +: 24] = 24'(al);
            ra[i*24 +: 24] = 24'(ar);
            lw[5*i +: 5]  = u[4:0];
            rw[6*i +: 6]  = 6'd32 - {1'b0, u[4:0]};
        end
        // Pack lanes at AB bits each
        out_next = '0;
        for (int i = 0; i < 4; i++)
        begin
            out_next.left_addrs_low   = out_next.left_addrs_low
                | 48'(la[i*24 +: 24] << (i*AB));
            out_next.left_addrs_high  = out_next.left_addrs_high
                | 48'(la[(i+4)*24 +: 24] << (i*AB));
            out_next.right_addrs_low  = out_next.right_addrs_low
                | 48'(ra[i*24 +: 24] << (i*AB));
            out_next.right_addrs_high = out_next.right_addrs_high
                | 48'(ra[(i+4)*24 +: 24] << (i*AB));
        end
        out_next.left_weights  = lw;
        out_next.right_weights = rw;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data <= out_next;
    end
endmodule

FILE: test/tb_top.sv
// Testbench for the beamforming delay address generator.
// Depends on bdag_pkg and beamform_delay_address_gen; predicts each output word.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LAT_WAIT = 80;
    localparam int WATCHDOG = 20000;

    // delay predictor and the store of expected output words
    class delay_scoreboard;
        logic [63:0] xpos;
        logic [63:0] ypos;
        logic [14:0] focal;
        bdag_pkg::out_word_t pending[$];
        int          errors;

        function new();
            xpos = '0;
            ypos = '0;
            focal = bdag_pkg::FOCAL_RESET;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [63:0] val);
            if (idx == bdag_pkg::REG_X)
                xpos = val;
            else if (idx == bdag_pkg::REG_Y)
                ypos = val;
            else if (idx == bdag_pkg::REG_FOCAL)
                focal = val[14:0];
        endfunction

        function longint unsigned root(longint unsigned v);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        function void note_input(bdag_pkg::in_word_t w);
            logic signed [7:0]   drow;
            longint              dcol, t, q, mn;
            longint              dl[8];
            longint unsigned     r2, c2, d2, dq, u, fr, ar, al;
            bdag_pkg::out_word_t o;
            drow = 8'(int'(w.pixel_row) * 2 - 71);
            dcol = longint'(w.pixel_col) * 2 - 127;
            r2 = (longint'(drow) * longint'(drow)) & 64'h1FFF;
            c2 = (dcol * dcol) & 64'h3FFF;
            d2 = (r2 + c2 + 4 * longint'(focal)) & 64'h1FFFF;
            dq = root(d2 << 18);
            for (int i = 0; i < 8; i++)
            begin
                t = longint'($signed(xpos[8*i +: 8])) * drow
                  + longint'($signed(ypos[8*i +: 8])) * dcol;
                q = 0;
                if (dq != 0)
                begin
                    q = (t * 2048) / longint'(dq);
                    if ((t * 2048) % longint'(dq) != 0 && t < 0)
                        q = q - 1;
                end
                dl[i] = longint'($signed(q[9:0]));
            end
            mn = dl[0];
            for (int i = 1; i < 8; i++)
                if (dl[i] < mn)
                    mn = dl[i];
            o = '0;
            for (int i = 0; i < 8; i++)
            begin
                u = (dl[i] - mn) & 64'h3FF;
                fr = u & 31;
                ar = (w.newest_addr - (u >> 5)) & 64'hFFF;
                al = (ar - 1) & 64'hFFF;
                if (i < 4)
                begin
                    o.left_addrs_low[12*i +: 12] = al[11:0];
                    o.right_addrs_low[12*i +: 12] = ar[11:0];
                end
                else
                begin
                    o.left_addrs_high[12*(i-4) +: 12] = al[11:0];
                    o.right_addrs_high[12*(i-4) +: 12] = ar[11:0];
                end
                o.left_weights[5*i +: 5] = fr[4:0];
                o.right_weights[6*i +: 6] = 6'(32 - fr);
            end
            pending.push_back(o);
        endfunction

        function void check_output(bdag_pkg::out_word_t got);
            bdag_pkg::out_word_t e;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected output word %h", got);
                return;
            end
            e = pending.pop_front();
            if (e !== got)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("mismatch lal exp %h got %h", e.left_addrs_low, got.left_addrs_low);
                    $display("  lah exp %h got %h", e.left_addrs_high, got.left_addrs_high);
                    $display("  ral exp %h got %h", e.right_addrs_low, got.right_addrs_low);
                    $display("  rah exp %h got %h", e.right_addrs_high, got.right_addrs_high);
                    $display("  lw exp %h got %h", e.left_weights, got.left_weights);
                    $display("  rw exp %h got %h", e.right_weights, got.right_weights);
                end
            end
        endfunction
    endclass

    logic                clk = 0;
    logic                rst_n = 0;
    logic                in_valid = 0;
    logic                in_ready;
    bdag_pkg::in_word_t  in_data = '0;
    logic                out_valid;
    logic                out_ready = 0;
    bdag_pkg::out_word_t out_data;
    logic                cfg_we = 0;
    logic [1:0]          cfg_index = '0;
    logic [63:0]         cfg_data = '0;
    int                  send_idle = 0;
    int                  recv_idle = 0;
    int                  quiet = 0;

    delay_scoreboard sb = new();

    always #2 clk = ~clk;

    beamform_delay_address_gen DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // check accepted words, randomize ready, watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_output(out_data);
            out_ready <= ($urandom_range(99) >= recv_idle);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet > WATCHDOG)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        @(posedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        sb.set_reg(idx, val);
        @(posedge clk);
        cfg_we <= 0;
    endtask

    // hold the word until accepted, idle at random first
    task automatic send_word(logic [6:0] r, logic [6:0] c, logic [11:0] a);
        bdag_pkg::in_word_t w;
        w.pixel_row = r;
        w.pixel_col = c;
        w.newest_addr = a;
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        in_data <= w;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(w);
    endtask

    // drop valid at once, then wait for every expected word
    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LAT_WAIT) @(posedge clk);
    endtask

    task automatic random_words(int n);
        for (int i = 0; i < n; i++)
            send_word($urandom_range(99) < 10 ? 7'($urandom_range(127)) : 7'($urandom_range(71)),
                      7'($urandom_range(127)), 12'($urandom_range(4095)));
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1;
        // directed: reset setting, extremes of the pixel and address fields
        send_word(7'd0, 7'd0, 12'd0);
        send_word(7'd71, 7'd127, 12'hFFF);
        send_word(7'd35, 7'd63, 12'd1);
        send_word(7'd36, 7'd64, 12'hAAA);
        drain();
        write_reg(bdag_pkg::REG_X, 64'h7F80_0102_FEFF_4010);
        write_reg(bdag_pkg::REG_Y, 64'h807F_FF01_10F0_2233);
        write_reg(bdag_pkg::REG_FOCAL, 15'd0);
        write_reg(2'd3, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(7'd0, 7'd0, 12'd0);
        send_word(7'd71, 7'd127, 12'hFFF);
        send_word(7'd127, 7'd0, 12'h555);
        send_word(7'd99, 7'd127, 12'd5);
        send_word(7'd98, 7'd1, 12'd7);
        send_word(7'd35, 7'd63, 12'd0);
        drain();
        write_reg(bdag_pkg::REG_FOCAL, 15'd27475);
        write_reg(bdag_pkg::REG_X, 64'h8080_8080_8080_8080);
        write_reg(bdag_pkg::REG_Y, 64'h7F7F_7F7F_7F7F_7F7F);
        send_word(7'd0, 7'd127, 12'd3);
        send_word(7'd71, 7'd0, 12'hFFE);
        send_word(7'd127, 7'd127, 12'd0);
        drain();
        // random phases with changing settings and idling profiles
        for (int ph = 0; ph < 6; ph++)
        begin
            send_idle = (ph < 2) ? 11 : (ph < 4) ? 58 : 0;
            recv_idle = (ph < 2) ? 58 : (ph < 4) ? 11 : 0;
            write_reg(bdag_pkg::REG_X, {$urandom, $urandom});
            write_reg(bdag_pkg::REG_Y, {$urandom, $urandom});
            write_reg(bdag_pkg::REG_FOCAL,
                      (ph == 5) ? 15'h7FFF : 15'($urandom_range(27475)));
            random_words(65);
            drain();
        end
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
